>>> rtl/cpus_pkg.sv
// Shared types and constants for the signed Cantor pairing/unpairing pipeline.
package cpus_pkg;

    // Coordinate width; key and diagonal widths follow from it
    localparam int COORD_BITS = 16;
    localparam int KEY_BITS   = 2 * COORD_BITS + 1;
    localparam int DIAG_BITS  = COORD_BITS + 1;
    localparam int CAND_BITS  = 2 * DIAG_BITS + 1;

    // Item kinds
    localparam logic KIND_PAIR   = 1'b0;
    localparam logic KIND_UNPAIR = 1'b1;

    // Input beat
    typedef struct packed {
        logic                         kind;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_z;
        logic        [KEY_BITS-1:0]   key_in;
    } in_t;

    // Result beat
    typedef struct packed {
        logic        [KEY_BITS-1:0]   key_out;
        logic signed [COORD_BITS-1:0] x_out;
        logic signed [COORD_BITS-1:0] z_out;
        logic                         range_error;
    } out_t;

    // Payload carried through the diagonal search stages
    typedef struct packed {
        logic                  kind;
        logic [KEY_BITS-1:0]   key;   // unpair key
        logic [DIAG_BITS-1:0]  s;     // diagonal found so far
        logic [KEY_BITS-1:0]   t;     // triangular number of s (pair: of ex+ez)
        logic [COORD_BITS-1:0] ez;    // encoded second coordinate (pair)
    } pipe_t;

endpackage

>>> rtl/cpus_diag_stage.sv
// One registered step of the diagonal search: decides a single bit of s.
module cpus_diag_stage #(
    parameter int STEP_BIT = 0
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  cpus_pkg::pipe_t in_data,
    output logic           out_valid,
    output cpus_pkg::pipe_t out_data
);
    import cpus_pkg::*;

    // T(2^b) = (4^b + 2^b) / 2
    localparam logic [CAND_BITS-1:0] ONE_C = 1;
    localparam logic [CAND_BITS-1:0] TRI_B =
        ((ONE_C << (2 * STEP_BIT)) + (ONE_C << STEP_BIT)) >> 1;

    logic [CAND_BITS-1:0] cand_t;
    logic [CAND_BITS-1:0] key_ext;
    logic                 take;
    pipe_t                data_next;
    pipe_t                data_reg;
    logic                 valid_reg;

    // T(s + 2^b) = T(s) + s * 2^b + T(2^b), with bit b of s still clear
    always_comb begin
        cand_t    = CAND_BITS'(in_data.t) + (CAND_BITS'(in_data.s) << STEP_BIT) + TRI_B;
        key_ext   = CAND_BITS'(in_data.key);
        take      = (in_data.kind == KIND_UNPAIR) && (cand_t <= key_ext);
        data_next = in_data;
        if (take) begin
            data_next.s[STEP_BIT] = 1'b1;
            data_next.t           = cand_t[KEY_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/cantor_pair_unpair_signed.sv
// Throughput: one beat per cycle while the output is not stalled; the square root
// is one pipeline stage per bit of the diagonal, and pairing uses a single
// registered multiplier stage.
// A one-entry input skid keeps s_ready registered while the output stalls.
// Reset (aresetn low, synchronous) empties every stage; payload registers keep junk.
module cantor_pair_unpair_signed (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  cpus_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output cpus_pkg::out_t m_data
);
    import cpus_pkg::*;

    localparam int PROD_BITS = KEY_BITS + 1;

    function automatic logic [COORD_BITS-1:0] zig_encode(input logic [COORD_BITS-1:0] u);
        zig_encode = {u[COORD_BITS-2:0], 1'b0} ^ {COORD_BITS{u[COORD_BITS-1]}};
    endfunction

    function automatic logic [COORD_BITS-1:0] zig_decode(input logic [COORD_BITS-1:0] e);
        zig_decode = {1'b0, e[COORD_BITS-1:1]} ^ {COORD_BITS{e[0]}};
    endfunction

    // Global advance: whole pipe moves unless the result register is stuck
    logic en;
    logic out_valid_reg;
    out_t out_reg;

    assign en = !out_valid_reg || m_ready;

    // Input skid: catches the beat accepted in a stalled cycle
    logic skid_valid_reg;
    logic skid_valid_next;
    in_t  skid_data_reg;
    logic src_valid;
    in_t  src_data;

    assign s_ready   = !skid_valid_reg;
    assign src_valid = skid_valid_reg ? 1'b1 : s_valid;
    assign src_data  = skid_valid_reg ? skid_data_reg : s_data;

    always_comb begin
        if (en) begin
            skid_valid_next = 1'b0;
        end else begin
            skid_valid_next = skid_valid_reg | s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!en && s_valid && !skid_valid_reg) begin
            skid_data_reg <= s_data;
        end
    end

    // Stage 0: zigzag encode and diagonal sum
    logic                  st0_valid_reg;
    logic                  st0_kind_reg;
    logic [KEY_BITS-1:0]   st0_key_reg;
    logic [COORD_BITS-1:0] st0_ez_reg;
    logic [DIAG_BITS-1:0]  st0_sum_reg;
    logic [COORD_BITS-1:0] ex_enc;
    logic [COORD_BITS-1:0] ez_enc;

    always_comb begin
        ex_enc = zig_encode(src_data.coord_x);
        ez_enc = zig_encode(src_data.coord_z);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st0_valid_reg <= 1'b0;
        end else if (en) begin
            st0_valid_reg <= src_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st0_kind_reg <= src_data.kind;
            st0_key_reg  <= src_data.key_in;
            st0_ez_reg   <= ez_enc;
            st0_sum_reg  <= DIAG_BITS'(ex_enc) + DIAG_BITS'(ez_enc);
        end
    end

    // Stage 1: triangular number of the pair sum
    logic [DIAG_BITS-1:0] sum_inc;
    logic [PROD_BITS-1:0] prod;
    pipe_t                st1_next;
    pipe_t                st1_reg;
    logic                 st1_valid_reg;

    always_comb begin
        sum_inc       = st0_sum_reg + 1'b1;
        prod          = PROD_BITS'(st0_sum_reg) * PROD_BITS'(sum_inc);
        st1_next.kind = st0_kind_reg;
        st1_next.key  = st0_key_reg;
        st1_next.s    = '0;
        st1_next.ez   = st0_ez_reg;
        if (st0_kind_reg == KIND_PAIR) begin
            st1_next.t = prod[KEY_BITS:1];
        end else begin
            st1_next.t = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (en) begin
            st1_valid_reg <= st0_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st1_reg <= st1_next;
        end
    end

    // Diagonal search: one stage per bit, most significant first
    pipe_t diag_data  [DIAG_BITS+1];
    logic  diag_valid [DIAG_BITS+1];

    assign diag_data[0]  = st1_reg;
    assign diag_valid[0] = st1_valid_reg;

    for (genvar i = 0; i < DIAG_BITS; i++) begin : g_diag
        cpus_diag_stage #(
            .STEP_BIT(DIAG_BITS - 1 - i)
        ) u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (diag_valid[i]),
            .in_data  (diag_data[i]),
            .out_valid(diag_valid[i+1]),
            .out_data (diag_data[i+1])
        );
    end

    // Finish 1: pair key sum, unpair second encoded value
    pipe_t                diag_last;
    logic                 fin_valid_reg;
    logic                 fin_kind_reg;
    logic [KEY_BITS-1:0]  fin_key_reg;
    logic [DIAG_BITS-1:0] fin_s_reg;
    logic [DIAG_BITS-1:0] fin_ezu_reg;
    logic [KEY_BITS-1:0]  key_diff;

    assign diag_last = diag_data[DIAG_BITS];
    assign key_diff  = diag_last.key - diag_last.t;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (en) begin
            fin_valid_reg <= diag_valid[DIAG_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fin_kind_reg <= diag_last.kind;
            fin_key_reg  <= diag_last.t + KEY_BITS'(diag_last.ez);
            fin_s_reg    <= diag_last.s;
            fin_ezu_reg  <= key_diff[DIAG_BITS-1:0];
        end
    end

    // Finish 2: first encoded value, range check, zigzag decode
    logic [DIAG_BITS-1:0] exu;
    logic                 range_bad;
    out_t                 out_next;

    always_comb begin
        exu       = fin_s_reg - fin_ezu_reg;
        range_bad = exu[COORD_BITS] | fin_ezu_reg[COORD_BITS];
        out_next  = '0;
        if (fin_kind_reg == KIND_PAIR) begin
            out_next.key_out = fin_key_reg;
        end else if (range_bad) begin
            out_next.range_error = 1'b1;
        end else begin
            out_next.x_out = zig_decode(exu[COORD_BITS-1:0]);
            out_next.z_out = zig_decode(fin_ezu_reg[COORD_BITS-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= fin_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
